FILE: hdl/c1ms_pkg.sv
package c1ms_pkg;

    localparam int MAX_IN_CH  = 16;
    localparam int MAX_OUT_CH = 8;
    localparam int MAX_KERNEL = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_STRIDE = 8;

    localparam int IC_W    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
    localparam int OC_W    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int K_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int POS_W   = $clog2(MAX_WIDTH);
    localparam int OW_W    = POS_W + 1;
    localparam int BASE_W  = POS_W + 5;
    localparam int WADDR_W = IC_W + K_W;
    localparam int RAM_DEPTH = 2 ** WADDR_W;

    localparam int SMP_W  = 16;
    localparam int BIAS_W = 32;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;

    // cycles from the last tap issue until the far cell has its sum
    localparam int DRAIN   = MAX_OUT_CH + 3;
    localparam int DRAIN_W = $clog2(DRAIN + 1);

    typedef enum logic [1:0] {
        REQ_WEIGHT = 2'd0,
        REQ_BIAS   = 2'd1,
        REQ_SAMPLE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_IN_CH  = 3'd0,
        CFG_OUT_CH = 3'd1,
        CFG_KSIZE  = 3'd2,
        CFG_STRIDE = 3'd3,
        CFG_PAD    = 3'd4,
        CFG_FWIDTH = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_WAIT,
        ST_OUT,
        ST_ERR
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] data_value;
        logic [2:0]         dest_out_channel;
        logic [3:0]         dest_in_channel;
        logic [2:0]         dest_tap;
    } c1ms_in_t;

    typedef struct packed {
        logic signed [39:0] out_value;
        logic [2:0]         out_channel;
        logic [9:0]         out_position;
        logic               status;
        logic               run_last;
    } c1ms_out_t;

    // one tap travelling down the cell row
    typedef struct packed {
        logic                    vld;
        logic                    use_tap;
        logic                    first;
        logic [WADDR_W-1:0]      waddr;
        logic signed [SMP_W-1:0] sample;
    } tap_t;

    typedef struct packed {
        logic               we;
        logic [WADDR_W-1:0] addr;
        logic [SMP_W-1:0]   data;
    } wt_wr_t;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [31:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/c1ms_ram.sv
module c1ms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/c1ms_cell.sv
// One output channel: own weight RAM, bias and accumulator.
// Taps pass through a register to the next cell.
module c1ms_cell
    import c1ms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wt_wr_t                  wt_wr,
    input  logic                    bias_we,
    input  logic signed [BIAS_W-1:0] bias_data,
    input  tap_t                    tap_in,
    output tap_t                    tap_out,
    output logic signed [ACC_W-1:0] acc
);

    tap_t                     tap_reg;
    logic                     vld2_reg;
    logic                     use2_reg;
    logic                     first2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [BIAS_W-1:0] bias_reg;
    logic [SMP_W-1:0]         w_rdata;

    c1ms_ram #(
        .WIDTH(SMP_W),
        .DEPTH(RAM_DEPTH)
    ) u_wram (
        .aclk (aclk),
        .we   (wt_wr.we),
        .waddr(wt_wr.addr),
        .wdata(wt_wr.data),
        .raddr(tap_in.waddr),
        .rdata(w_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg  <= '0;
            vld2_reg <= 1'b0;
        end else begin
            tap_reg  <= tap_in;
            vld2_reg <= tap_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        use2_reg   <= tap_reg.use_tap;
        first2_reg <= tap_reg.first;
        prod_reg   <= tap_reg.sample * $signed(w_rdata);
        if (bias_we) begin
            bias_reg <= bias_data;
        end
        if (vld2_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        acc_next = first2_reg ? ACC_W'(bias_reg) : acc_reg;
        if (use2_reg) begin
            acc_next = acc_next + ACC_W'(prod_reg);
        end
    end

    assign tap_out = tap_reg;
    assign acc     = acc_reg;

endmodule

FILE: hdl/conv1d_multichannel_stream_core.sv
// Streaming multichannel 1D convolution with stride, zero padding and a bias per output
// channel. Weight (req_type 0) and bias (req_type 1) transfers load the stores; samples
// (req_type 2) arrive position-major with input channel inner, one frame of frame_width
// positions after another. When a position's last channel lands, every output position
// whose window is complete is computed and sent, one result per output channel, with
// run_last on the final one. For each output position, each input channel's taps are
// issued one a cycle from the window RAM down a row of MAC cells, one cell per output
// channel, then the row drains and results leave one per cycle while m_ready is high.
// With an invalid configuration each sample gives one result with status 1 and value zero.
// A configuration write in the idle state restarts the frame; stores keep their contents.
module conv1d_multichannel_stream_core
    import c1ms_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  c1ms_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output c1ms_out_t m_data,
    input  logic      cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    // configuration registers
    logic [4:0]  in_ch_reg;
    logic [3:0]  out_ch_reg;
    logic [3:0]  ksz_reg;
    logic [3:0]  stride_reg;
    logic [2:0]  pad_reg;
    logic [10:0] fw_reg;

    // stream control
    state_t              state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [IC_W-1:0]     ch_reg, ch_next;
    logic [OW_W-1:0]     ow_reg, ow_next;
    logic [BASE_W-1:0]   base_reg, base_next;   // ow_reg * stride, kept as a running sum
    logic [IC_W-1:0]     ic_reg, ic_next;
    logic [K_W-1:0]      t_reg, t_next;
    logic [OC_W-1:0]     oc_reg, oc_next;
    logic [DRAIN_W-1:0]  drain_reg, drain_next;
    tap_t                issue_reg, issue_next;
    logic                m_valid_reg, m_valid_next;
    c1ms_out_t           m_data_reg, m_data_next;

    logic                  cfg_ok;
    logic                  s_xfer;
    logic                  win_we;
    logic [WADDR_W-1:0]    win_waddr;
    logic [WADDR_W-1:0]    win_raddr;
    logic [SMP_W-1:0]      win_rdata;
    logic signed [SMP_W-1:0] smp_sat;
    logic                  wt_we;
    logic                  bias_we;
    logic [BASE_W:0]       raw_tap;
    logic [BASE_W:0]       iw_tap;
    logic                  cur_ready;
    logic                  nxt_ready;

    tap_t                    chain [MAX_OUT_CH+1];
    logic signed [ACC_W-1:0] cell_acc [MAX_OUT_CH];

    // output position with base b is due once its clipped window end is reached
    function automatic logic ow_ready(
        input logic [BASE_W-1:0] b,
        input logic [3:0]        k,
        input logic [2:0]        p,
        input logic [10:0]       fw,
        input logic [POS_W-1:0]  pos
    );
        logic [BASE_W+1:0] span;
        logic [BASE_W+1:0] endr;
        logic [BASE_W+1:0] fwm1;
        logic [BASE_W+1:0] endc;
        logic              ok;
        span = (BASE_W+2)'(fw) + (BASE_W+2)'({p, 1'b0});
        ok   = ((BASE_W+2)'(b) + (BASE_W+2)'(k)) <= span;
        endr = (BASE_W+2)'(b) + (BASE_W+2)'(k) - (BASE_W+2)'(1) - (BASE_W+2)'(p);
        fwm1 = (BASE_W+2)'(fw) - (BASE_W+2)'(1);
        endc = (endr > fwm1) ? fwm1 : endr;
        return ok && (endc <= (BASE_W+2)'(pos));
    endfunction

    always_comb begin
        cfg_ok = 1'b1;
        if (in_ch_reg < 5'd1 || 32'(in_ch_reg) > MAX_IN_CH) cfg_ok = 1'b0;
        if (out_ch_reg < 4'd1 || 32'(out_ch_reg) > MAX_OUT_CH) cfg_ok = 1'b0;
        if (ksz_reg < 4'd1 || 32'(ksz_reg) > MAX_KERNEL) cfg_ok = 1'b0;
        if (stride_reg < 4'd1 || 32'(stride_reg) > MAX_STRIDE) cfg_ok = 1'b0;
        if (4'(pad_reg) >= ksz_reg) cfg_ok = 1'b0;
        if (fw_reg < 11'd1 || 32'(fw_reg) > MAX_WIDTH) cfg_ok = 1'b0;
        if ((12'(fw_reg) + 12'({pad_reg, 1'b0})) < 12'(ksz_reg)) cfg_ok = 1'b0;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign smp_sat = sat16(s_data.data_value);

    assign cur_ready = ow_ready(base_reg, ksz_reg, pad_reg, fw_reg, pos_reg);
    assign nxt_ready = ow_ready(base_reg + BASE_W'(stride_reg), ksz_reg, pad_reg, fw_reg,
                                pos_reg);

    // tap address math for the tap being issued
    assign raw_tap   = (BASE_W+1)'(base_reg) + (BASE_W+1)'(t_reg);
    assign iw_tap    = raw_tap - (BASE_W+1)'(pad_reg);
    assign win_raddr = {iw_tap[K_W-1:0], ic_reg};

    // loads and window writes
    assign wt_we   = s_xfer && (s_data.req_type == REQ_WEIGHT)
                     && (32'(s_data.dest_out_channel) < MAX_OUT_CH)
                     && (32'(s_data.dest_in_channel) < MAX_IN_CH)
                     && (32'(s_data.dest_tap) < MAX_KERNEL);
    assign bias_we = s_xfer && (s_data.req_type == REQ_BIAS)
                     && (32'(s_data.dest_out_channel) < MAX_OUT_CH);
    assign win_we    = s_xfer && (s_data.req_type == REQ_SAMPLE) && cfg_ok;
    assign win_waddr = {pos_reg[K_W-1:0], ch_reg};

    c1ms_ram #(
        .WIDTH(SMP_W),
        .DEPTH(RAM_DEPTH)
    ) u_win_ram (
        .aclk (aclk),
        .we   (win_we),
        .waddr(win_waddr),
        .wdata(smp_sat),
        .raddr(win_raddr),
        .rdata(win_rdata)
    );

    // head of the cell row: issued tap meets the window sample read last cycle
    always_comb begin
        chain[0]        = issue_reg;
        chain[0].sample = $signed(win_rdata);
    end

    for (genvar g = 0; g < MAX_OUT_CH; g++) begin : g_cell
        wt_wr_t cell_wr;

        always_comb begin
            cell_wr.we   = wt_we && (32'(s_data.dest_out_channel) == g);
            cell_wr.addr = {s_data.dest_in_channel[IC_W-1:0], s_data.dest_tap[K_W-1:0]};
            cell_wr.data = smp_sat;
        end

        c1ms_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wt_wr    (cell_wr),
            .bias_we  (bias_we && (32'(s_data.dest_out_channel) == g)),
            .bias_data(s_data.data_value),
            .tap_in   (chain[g]),
            .tap_out  (chain[g+1]),
            .acc      (cell_acc[g])
        );
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= 5'd1;
            out_ch_reg <= 4'd1;
            ksz_reg    <= 4'd3;
            stride_reg <= 4'd1;
            pad_reg    <= 3'd0;
            fw_reg     <= 11'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IN_CH:  in_ch_reg  <= cfg_data[4:0];
                CFG_OUT_CH: out_ch_reg <= cfg_data[3:0];
                CFG_KSIZE:  ksz_reg    <= cfg_data[3:0];
                CFG_STRIDE: stride_reg <= cfg_data[3:0];
                CFG_PAD:    pad_reg    <= cfg_data[2:0];
                CFG_FWIDTH: fw_reg     <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            ch_reg      <= '0;
            ow_reg      <= '0;
            base_reg    <= '0;
            ic_reg      <= '0;
            t_reg       <= '0;
            oc_reg      <= '0;
            drain_reg   <= '0;
            issue_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            ch_reg      <= ch_next;
            ow_reg      <= ow_next;
            base_reg    <= base_next;
            ic_reg      <= ic_next;
            t_reg       <= t_next;
            oc_reg      <= oc_next;
            drain_reg   <= drain_next;
            issue_reg   <= issue_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        ch_next      = ch_reg;
        ow_next      = ow_reg;
        base_next    = base_reg;
        ic_next      = ic_reg;
        t_next       = t_reg;
        oc_next      = oc_reg;
        drain_next   = drain_reg;
        issue_next   = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cfg_we && (32'(cfg_index) <= 32'(CFG_FWIDTH))) begin
                    // any register write starts a new frame
                    pos_next  = '0;
                    ch_next   = '0;
                    ow_next   = '0;
                    base_next = '0;
                end else if (s_xfer && (s_data.req_type == REQ_SAMPLE)) begin
                    if (!cfg_ok) begin
                        state_next = ST_ERR;
                    end else if ((5'(ch_reg) + 5'd1) < in_ch_reg) begin
                        ch_next = ch_reg + IC_W'(1);
                    end else begin
                        ch_next    = '0;
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK: begin
                if (cur_ready) begin
                    ic_next    = '0;
                    t_next     = '0;
                    state_next = ST_RUN;
                end else begin
                    // this position is done; advance or close the frame
                    if ((11'(pos_reg) + 11'd1) >= fw_reg) begin
                        pos_next  = '0;
                        ch_next   = '0;
                        ow_next   = '0;
                        base_next = '0;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_RUN: begin
                // taps in the padding or beyond the frame add nothing
                issue_next.vld     = 1'b1;
                issue_next.use_tap = (raw_tap >= (BASE_W+1)'(pad_reg))
                                     && (iw_tap < (BASE_W+1)'(fw_reg))
                                     && (iw_tap <= (BASE_W+1)'(pos_reg));
                issue_next.first   = (ic_reg == '0) && (t_reg == '0);
                issue_next.waddr   = {ic_reg, t_reg};
                if (4'(t_reg) == (ksz_reg - 4'd1)) begin
                    t_next = '0;
                    if (5'(ic_reg) == (in_ch_reg - 5'd1)) begin
                        drain_next = DRAIN_W'(DRAIN);
                        state_next = ST_WAIT;
                    end else begin
                        ic_next = ic_reg + IC_W'(1);
                    end
                end else begin
                    t_next = t_reg + K_W'(1);
                end
            end

            ST_WAIT: begin
                if (drain_reg == DRAIN_W'(1)) begin
                    oc_next    = '0;
                    state_next = ST_OUT;
                end else begin
                    drain_next = drain_reg - DRAIN_W'(1);
                end
            end

            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.out_value     = cell_acc[oc_reg];
                    m_data_next.out_channel   = 3'(oc_reg);
                    m_data_next.out_position  = ow_reg[9:0];
                    m_data_next.status        = 1'b0;
                    m_data_next.run_last      = 1'b0;
                    if (4'(oc_reg) == (out_ch_reg - 4'd1)) begin
                        // last channel of this position: flag if no further position is due
                        m_data_next.run_last = !nxt_ready;
                        ow_next    = ow_reg + OW_W'(1);
                        base_next  = base_reg + BASE_W'(stride_reg);
                        state_next = ST_CHECK;
                    end else begin
                        oc_next = oc_reg + OC_W'(1);
                    end
                end
            end

            ST_ERR: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.out_value    = '0;
                    m_data_next.out_channel  = '0;
                    m_data_next.out_position = '0;
                    m_data_next.status       = 1'b1;
                    m_data_next.run_last     = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/c1ms_checker.sv
module c1ms_checker
    import c1ms_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input c1ms_out_t m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // config error result is a single zero result
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |->
            m_data.run_last && (m_data.out_value == '0) && (m_data.out_channel == '0)
            && (m_data.out_position == '0))
        else $error("malformed status result");

    // no new input while a run of results is still going
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.run_last |-> !s_ready)
        else $error("input taken during a result run");

endmodule

bind conv1d_multichannel_stream_core c1ms_checker u_c1ms_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
